>>> hw/rtl/pixel_replicate_upscaler_macros.svh
// assertion macros shared by the upscaler checker
`ifndef PIXEL_REPLICATE_UPSCALER_MACROS_SVH
`define PIXEL_REPLICATE_UPSCALER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PRU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("upscaler check failed");

// next-cycle implication, disabled while reset is low
`define PRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("upscaler check failed");

`endif

>>> hw/rtl/pru_pkg.sv
// shared types and constants for the pixel replicate upscaler
`default_nettype none

package pru_pkg;

  localparam int FACTOR_W = 7;
  localparam int SRCW_W   = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SCALE_FACTOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SOURCE_WIDTH = 1'd1;

  localparam logic [FACTOR_W-1:0] FACTOR_MAX = 7'd100;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_BUSY     = 3'd1;
  localparam logic [2:0] ST_PIXEL    = 3'd2;
  localparam logic [2:0] ST_PAD      = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  // command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PW    = 2;
  localparam int Q_CW    = 3;

  typedef struct packed {
    logic       op;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pru_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       row_end;
    logic       burst_end;
  } pru_out_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pru_pix_t;

  typedef struct packed {
    logic [2:0] status;
    logic       row_end;
    logic       burst_end;
  } pru_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/pixel_replicate_upscaler.sv
// top level: integer nearest-neighbor upscaler for 24-bit pixel rows
// throughput: one request per cycle, push or pull, whenever out_stall stays low
// each accepted request passes through the queue write, the line store read and the output register
// the four-entry command queue lets the front keep taking requests while the output is stalled
// reset: synchronous active-low rst_n clears the counters, pipeline valids and queue,
//   sets scale_factor and source_width to 1; the line store is not cleared
`default_nettype none

module pixel_replicate_upscaler #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // request channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire pru_pkg::pru_in_t              in_data,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output pru_pkg::pru_out_t                  out_data,
  // register writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pru_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pru_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // settings registers, always writable
  logic [FACTOR_W-1:0] scale_factor_r;
  logic [SRCW_W-1:0]   source_width_r;

  // front to queue
  logic           f_push;
  pru_cmd_t       f_cmd;
  logic [AW-1:0]  f_addr;
  pru_pix_t       f_pix;
  logic           q_full;

  // queue to back
  logic           q_valid;
  logic           q_pop;
  pru_cmd_t       q_cmd;
  logic [AW-1:0]  q_addr;
  pru_pix_t       q_pix;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_factor_r <= 7'd1;
      source_width_r <= 11'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_SCALE_FACTOR: scale_factor_r <= cfg_data[FACTOR_W-1:0];
        CFG_IDX_SOURCE_WIDTH: source_width_r <= cfg_data[SRCW_W-1:0];
        default: ;
      endcase
    end
  end

  // front: decides each request's outcome at acceptance and steps the
  // fill and playout counters; pixel reads and writes go out as commands
  pru_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .scale_factor(scale_factor_r),
    .source_width(source_width_r),
    .q_full      (q_full),
    .q_push      (f_push),
    .q_cmd       (f_cmd),
    .q_addr      (f_addr),
    .q_pix       (f_pix)
  );

  // decouples the counters from output back-pressure
  pru_queue #(
    .AW(AW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_push),
    .cmd_in  (f_cmd),
    .addr_in (f_addr),
    .pix_in  (f_pix),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .cmd_out (q_cmd),
    .addr_out(q_addr),
    .pix_out (q_pix)
  );

  // back: line store in command order, so a row's writes land before its reads
  pru_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_addr   (q_addr),
    .q_pix    (q_pix),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

>>> hw/rtl/pru_front.sv
// front end: classifies requests, runs the playout counters, issues commands
`default_nettype none

module pru_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire pru_pkg::pru_in_t            in_data,
  input  wire logic [pru_pkg::FACTOR_W-1:0] scale_factor,
  input  wire logic [pru_pkg::SRCW_W-1:0]   source_width,
  input  wire logic                        q_full,
  output logic                             q_push,
  output pru_pkg::pru_cmd_t                q_cmd,
  output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] q_addr,
  output pru_pkg::pru_pix_t                q_pix
);
  import pru_pkg::*;

  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int MWB = $clog2(MAX_WIDTH + 1);
  localparam int WW  = (MWB > SRCW_W) ? MWB : SRCW_W;
  localparam logic [WW-1:0] MAXW = WW'(MAX_WIDTH);

  logic                playing_r, playing_nxt;
  logic [WW-1:0]       fill_r, fill_nxt;
  logic [WW-1:0]       idx_r, idx_nxt;
  logic [FACTOR_W-1:0] rep_r, rep_nxt;
  logic [FACTOR_W-1:0] row_r, row_nxt;
  logic [1:0]          pad_r, pad_nxt;

  logic [FACTOR_W-1:0] ef;
  logic [WW-1:0]       ew;
  logic [WW-1:0]       width_x;
  logic [3:0]          pad_prod;
  logic [1:0]          pad_tot;
  logic [WW-1:0]       fill_inc, idx_inc;
  logic [FACTOR_W-1:0] rep_inc, row_inc;
  logic                finish;
  logic                accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  // out-of-range settings clamp
  assign width_x = WW'(source_width);
  always_comb begin
    if (scale_factor == '0) ef = 7'd1;
    else if (scale_factor > FACTOR_MAX) ef = FACTOR_MAX;
    else ef = scale_factor;
    if (width_x == '0) ew = WW'(1);
    else if (width_x > MAXW) ew = MAXW;
    else ew = width_x;
  end

  // pad count is (width * factor) mod 4
  assign pad_prod = {2'b00, ew[1:0]} * {2'b00, ef[1:0]};
  assign pad_tot  = pad_prod[1:0];

  assign fill_inc = fill_r + WW'(1);
  assign idx_inc  = idx_r + WW'(1);
  assign rep_inc  = rep_r + 7'd1;
  assign row_inc  = row_r + 7'd1;

  always_comb begin
    playing_nxt = playing_r;
    fill_nxt    = fill_r;
    idx_nxt     = idx_r;
    rep_nxt     = rep_r;
    row_nxt     = row_r;
    pad_nxt     = pad_r;
    finish      = 1'b0;
    q_cmd       = '0;
    q_addr      = '0;
    q_pix.blue  = in_data.blue;
    q_pix.green = in_data.green;
    q_pix.red   = in_data.red;
    if (!in_data.op) begin
      if (playing_r) begin
        q_cmd.status = ST_BUSY;
      end else begin
        q_cmd.status = ST_ACCEPTED;
        q_addr       = fill_r[AW-1:0];
        fill_nxt     = fill_inc;
        if (fill_inc >= ew) begin
          playing_nxt = 1'b1;
          idx_nxt     = '0;
          rep_nxt     = '0;
          row_nxt     = '0;
          pad_nxt     = '0;
        end
      end
    end else if (!playing_r) begin
      q_cmd.status = ST_EMPTY;
    end else if (pad_r != 2'd0) begin
      q_cmd.status = ST_PAD;
      pad_nxt      = pad_r - 2'd1;
      if (pad_r == 2'd1) begin
        q_cmd.row_end = 1'b1;
        finish        = 1'b1;
      end
    end else begin
      q_cmd.status = ST_PIXEL;
      q_addr       = idx_r[AW-1:0];
      if (rep_inc >= ef) begin
        rep_nxt = '0;
        if (idx_inc >= ew) begin
          idx_nxt = '0;
          if (pad_tot == 2'd0) begin
            q_cmd.row_end = 1'b1;
            finish        = 1'b1;
          end else begin
            pad_nxt = pad_tot;
          end
        end else begin
          idx_nxt = idx_inc;
        end
      end else begin
        rep_nxt = rep_inc;
      end
    end
    // close the row copy, and the burst after the last copy
    if (finish) begin
      if (row_inc >= ef) begin
        row_nxt         = '0;
        playing_nxt     = 1'b0;
        fill_nxt        = '0;
        idx_nxt         = '0;
        rep_nxt         = '0;
        pad_nxt         = '0;
        q_cmd.burst_end = 1'b1;
      end else begin
        row_nxt = row_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r <= 1'b0;
      fill_r    <= '0;
      idx_r     <= '0;
      rep_r     <= '0;
      row_r     <= '0;
      pad_r     <= '0;
    end else if (accept) begin
      playing_r <= playing_nxt;
      fill_r    <= fill_nxt;
      idx_r     <= idx_nxt;
      rep_r     <= rep_nxt;
      row_r     <= row_nxt;
      pad_r     <= pad_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pru_queue.sv
// short command queue between front and back
`default_nettype none

module pru_queue #(
  parameter int AW = 10
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire pru_pkg::pru_cmd_t cmd_in,
  input  wire logic [AW-1:0]     addr_in,
  input  wire pru_pkg::pru_pix_t pix_in,
  output logic                   full,
  input  wire logic              pop,
  output logic                   valid,
  output pru_pkg::pru_cmd_t      cmd_out,
  output logic [AW-1:0]          addr_out,
  output pru_pkg::pru_pix_t      pix_out
);
  import pru_pkg::*;

  pru_cmd_t       cmd_q  [Q_DEPTH];
  logic [AW-1:0]  addr_q [Q_DEPTH];
  pru_pix_t       pix_q  [Q_DEPTH];
  logic [Q_PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign full     = (count_r == Q_CW'(Q_DEPTH));
  assign valid    = (count_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign cmd_out  = cmd_q[rd_ptr_r];
  assign addr_out = addr_q[rd_ptr_r];
  assign pix_out  = pix_q[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + Q_CW'(1);
    else if (do_pop && !do_push) count_nxt = count_r - Q_CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + Q_PW'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + Q_PW'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      cmd_q[wr_ptr_r]  <= cmd_in;
      addr_q[wr_ptr_r] <= addr_in;
      pix_q[wr_ptr_r]  <= pix_in;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pru_back.sv
// back end: line store access and the registered result stage
`default_nettype none

module pru_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire pru_pkg::pru_cmd_t q_cmd,
  input  wire logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] q_addr,
  input  wire pru_pkg::pru_pix_t q_pix,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pru_pkg::pru_out_t      out_data
);
  import pru_pkg::*;

  pru_pix_t  line_store [MAX_WIDTH];
  pru_pix_t  rd_data_r;
  pru_cmd_t  s1_cmd_r;
  logic      s1_valid_r;
  logic      out_valid_r;
  pru_out_t  out_data_r, out_nxt;
  logic      adv_out;

  assign adv_out   = !out_valid_r || !out_stall;
  assign q_pop     = q_valid && (!s1_valid_r || adv_out);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // line store: write on accepted pushes, registered read on every pop
  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_cmd.status == ST_ACCEPTED) line_store[q_addr] <= q_pix;
      rd_data_r <= line_store[q_addr];
      s1_cmd_r  <= q_cmd;
    end
  end

  always_comb begin
    out_nxt.status    = s1_cmd_r.status;
    out_nxt.row_end   = s1_cmd_r.row_end;
    out_nxt.burst_end = s1_cmd_r.burst_end;
    if (s1_cmd_r.status == ST_PIXEL) begin
      out_nxt.out_blue  = rd_data_r.blue;
      out_nxt.out_green = rd_data_r.green;
      out_nxt.out_red   = rd_data_r.red;
    end else begin
      out_nxt.out_blue  = 8'h00;
      out_nxt.out_green = 8'h00;
      out_nxt.out_red   = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) s1_valid_r <= 1'b1;
      else if (adv_out) s1_valid_r <= 1'b0;
      if (adv_out) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid_r) out_data_r <= out_nxt;
  end

endmodule

`default_nettype wire

>>> hw/rtl/pru_checker.sv
// port-level checker for the upscaler, bound to the top level
`default_nettype none
`include "pixel_replicate_upscaler_macros.svh"

module pru_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire pru_pkg::pru_out_t out_data
);
  import pru_pkg::*;

  // a stalled result stays put
  `PRU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // color bytes only on pixel results
  `PRU_ASSERT_NOW(a_zero_color, clk, rst_n, out_valid && (out_data.status != ST_PIXEL), (out_data.out_blue == 8'h00) && (out_data.out_green == 8'h00) && (out_data.out_red == 8'h00))

  // the burst ends on a row end
  `PRU_ASSERT_NOW(a_burst_row, clk, rst_n, out_valid && out_data.burst_end, out_data.row_end)

  // flags only on pixel and pad results
  `PRU_ASSERT_NOW(a_flag_kind, clk, rst_n, out_valid && (out_data.status != ST_PIXEL) && (out_data.status != ST_PAD), !out_data.row_end && !out_data.burst_end)

endmodule

bind pixel_replicate_upscaler pru_checker u_pru_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

`default_nettype wire

>>> dv/pixel_replicate_upscaler_tb.sv
// self-checking testbench for the pixel replicate upscaler: directed table, then random rows
`default_nettype none

module pixel_replicate_upscaler_tb;
  import pru_pkg::*;

  localparam int MAX_WIDTH = 1024;
  localparam int HOLD_CYCLES = 80;
  localparam int MAX_PRINTS = 50;
  localparam longint TIMEOUT = 64'd20_000_000;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  typedef logic [CFG_DATA_W-1:0] reg_val_t;
  typedef enum logic {ROW_REG, ROW_REQ} row_kind_t;

  // one line of the directed table; known marks a hand-written expected status
  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    reg_val_t              reg_val;
    pru_in_t               req;
    logic                  known;
    logic [2:0]            known_status;
  } step_row_t;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid;
  logic     in_stall;
  pru_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  pru_out_t out_data;
  logic     cfg_valid;
  logic     cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  reg_val_t cfg_data;

  // shared between the request driver and the result stall process
  bit calm = 1'b0;
  bit hold_go = 1'b0;

  int mismatch_count = 0;
  int result_count = 0;
  pru_out_t due_results[$];
  step_row_t directed_steps[$];

  // predictor copy of the registers and the block state
  logic [FACTOR_W-1:0] cfg_factor = 7'd1;
  logic [SRCW_W-1:0]   cfg_width = 11'd1;
  pru_pix_t    line_mem [0:MAX_WIDTH-1];
  int unsigned filled_upto = 0;
  int unsigned fill_cnt = 0;
  bit          playing = 1'b0;
  int unsigned rd_idx = 0;
  int unsigned rep_cnt = 0;
  int unsigned copy_cnt = 0;
  int unsigned pad_left = 0;

  pixel_replicate_upscaler #(
    .MAX_WIDTH(MAX_WIDTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(TIMEOUT);
    $display("TEST FAILED");
    $finish;
  end

  function automatic int unsigned eff_factor();
    if (cfg_factor == 0) return 1;
    if (cfg_factor > FACTOR_MAX) return FACTOR_MAX;
    return cfg_factor;
  endfunction

  function automatic int unsigned eff_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
    return cfg_width;
  endfunction

  // zero bytes that bring an output row of 3*w*f bytes to a multiple of four
  function automatic int unsigned row_pad(int unsigned w, int unsigned f);
    int unsigned m;
    m = (3 * ((w * f) & 3)) & 3;
    return (4 - m) & 3;
  endfunction

  // one row copy done; returns 1 when that was the last copy of the burst
  function automatic logic close_row_copy();
    copy_cnt++;
    if (copy_cnt >= eff_factor()) begin
      copy_cnt = 0;
      playing = 1'b0;
      fill_cnt = 0;
      rd_idx = 0;
      rep_cnt = 0;
      pad_left = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // advances the predicted state by one request and returns its result
  function automatic pru_out_t upscale_step(pru_in_t req);
    pru_out_t    res;
    int unsigned f;
    int unsigned w;
    res = '0;
    f = eff_factor();
    w = eff_width();
    if (req.op == OP_PUSH) begin
      if (playing) begin
        res.status = ST_BUSY;
        return res;
      end
      if (fill_cnt < MAX_WIDTH) begin
        line_mem[fill_cnt] = '{blue: req.blue, green: req.green, red: req.red};
        if (fill_cnt + 1 > filled_upto) filled_upto = fill_cnt + 1;
      end
      fill_cnt++;
      if (fill_cnt >= w) begin
        playing = 1'b1;
        rd_idx = 0;
        rep_cnt = 0;
        copy_cnt = 0;
        pad_left = 0;
      end
      res.status = ST_ACCEPTED;
      return res;
    end
    if (!playing) begin
      res.status = ST_EMPTY;
      return res;
    end
    // pad phase of the current row copy
    if (pad_left != 0) begin
      res.status = ST_PAD;
      pad_left--;
      if (pad_left == 0) begin
        res.row_end = 1'b1;
        res.burst_end = close_row_copy();
      end
      return res;
    end
    res.status = ST_PIXEL;
    res.out_blue = line_mem[rd_idx].blue;
    res.out_green = line_mem[rd_idx].green;
    res.out_red = line_mem[rd_idx].red;
    rep_cnt++;
    if (rep_cnt >= f) begin
      rep_cnt = 0;
      rd_idx++;
      if (rd_idx >= w) begin
        rd_idx = 0;
        if (row_pad(w, f) == 0) begin
          res.row_end = 1'b1;
          res.burst_end = close_row_copy();
        end else begin
          pad_left = row_pad(w, f);
        end
      end
    end
    return res;
  endfunction

  function automatic step_row_t reg_row(logic [CFG_IDX_W-1:0] idx, reg_val_t val);
    step_row_t row;
    row = '{kind: ROW_REG, reg_idx: idx, reg_val: val, req: '0, known: 1'b0,
            known_status: ST_ACCEPTED};
    return row;
  endfunction

  function automatic step_row_t req_row(logic op, logic [7:0] b, logic [7:0] g,
                                        logic [7:0] r, logic known, logic [2:0] status);
    step_row_t row;
    row = '{kind: ROW_REQ, reg_idx: '0, reg_val: '0,
            req: '{op: op, blue: b, green: g, red: r}, known: known, known_status: status};
    return row;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  // offers one request, with random gaps ahead of it, and records its result once taken
  task automatic send_req(input pru_in_t req, input logic known, input logic [2:0] status);
    pru_out_t predicted;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    predicted = upscale_step(req);
    if (known) begin
      predicted = '0;
      predicted.status = status;
    end
    due_results.push_back(predicted);
  endtask

  // block is idle once every result is back plus its pipeline depth
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input reg_val_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_IDX_SCALE_FACTOR) cfg_factor = val[FACTOR_W-1:0];
    else cfg_width = val[SRCW_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly whole rows (fill, then pull the burst), with stray requests and
  // register changes between requests; the phase always ends back in collecting
  task automatic run_phase(input reg_val_t factor_val, input reg_val_t width_val,
                           input int budget, input bit squeeze);
    pru_in_t     req;
    int          counted;
    int unsigned lim;
    counted = 0;
    wait_drained();
    write_reg(CFG_IDX_SCALE_FACTOR, factor_val);
    write_reg(CFG_IDX_SOURCE_WIDTH, width_val);
    if (squeeze) hold_go = 1'b1;
    while (counted < budget) begin
      req.blue = 8'($urandom);
      req.green = 8'($urandom);
      req.red = 8'($urandom);
      if ($urandom_range(99) < 3) begin
        // while playing out, keep the width inside the part of the store already written
        lim = (playing && filled_upto < 9) ? filled_upto : 9;
        wait_drained();
        write_reg(CFG_IDX_SCALE_FACTOR, reg_val_t'($urandom_range(0, 6)));
        write_reg(CFG_IDX_SOURCE_WIDTH, reg_val_t'($urandom_range(0, lim)));
      end else if ($urandom_range(99) < 8) begin
        req.op = 1'($urandom);
        send_req(req, 1'b0, ST_ACCEPTED);
      end else begin
        req.op = playing ? OP_PULL : OP_PUSH;
        send_req(req, 1'b0, ST_ACCEPTED);
        counted++;
      end
    end
    while (fill_cnt != 0 || playing) begin
      req.blue = 8'($urandom);
      req.green = 8'($urandom);
      req.red = 8'($urandom);
      req.op = playing ? OP_PULL : OP_PUSH;
      send_req(req, 1'b0, ST_ACCEPTED);
    end
  endtask

  // result stall: random, quiet during calm stretches, one long hold-off on request
  initial begin : result_stall
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 35);
      end
    end
  end

  // results are compared in order against the oldest outstanding expectation
  always @(posedge clk) begin : result_check
    pru_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        flag_mismatch($sformatf("result %0d with no request outstanding, status %0d",
                                result_count, out_data.status));
      end else begin
        want = due_results.pop_front();
        if (out_data.status !== want.status)
          flag_mismatch($sformatf("result %0d status %0d, expected %0d",
                                  result_count, out_data.status, want.status));
        if (out_data.out_blue !== want.out_blue)
          flag_mismatch($sformatf("result %0d blue %0h, expected %0h",
                                  result_count, out_data.out_blue, want.out_blue));
        if (out_data.out_green !== want.out_green)
          flag_mismatch($sformatf("result %0d green %0h, expected %0h",
                                  result_count, out_data.out_green, want.out_green));
        if (out_data.out_red !== want.out_red)
          flag_mismatch($sformatf("result %0d red %0h, expected %0h",
                                  result_count, out_data.out_red, want.out_red));
        if (out_data.row_end !== want.row_end)
          flag_mismatch($sformatf("result %0d row_end %0b, expected %0b",
                                  result_count, out_data.row_end, want.row_end));
        if (out_data.burst_end !== want.burst_end)
          flag_mismatch($sformatf("result %0d burst_end %0b, expected %0b",
                                  result_count, out_data.burst_end, want.burst_end));
      end
      result_count++;
    end
  end

  initial begin : stimulus
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;

    // after reset: width 1, factor 1, so one pixel and one pad byte per row
    directed_steps.push_back(req_row(OP_PULL, 8'h00, 8'h00, 8'h00, 1'b1, ST_EMPTY));
    directed_steps.push_back(req_row(OP_PUSH, 8'hff, 8'h00, 8'hff, 1'b1, ST_ACCEPTED));
    directed_steps.push_back(req_row(OP_PUSH, 8'h00, 8'hff, 8'h00, 1'b1, ST_BUSY));
    directed_steps.push_back(req_row(OP_PULL, 8'h00, 8'h00, 8'h00, 1'b0, ST_ACCEPTED));
    directed_steps.push_back(req_row(OP_PULL, 8'hff, 8'hff, 8'hff, 1'b0, ST_ACCEPTED));
    directed_steps.push_back(req_row(OP_PULL, 8'h00, 8'h00, 8'h00, 1'b1, ST_EMPTY));
    // zero in both registers acts as one
    directed_steps.push_back(reg_row(CFG_IDX_SCALE_FACTOR, 11'd0));
    directed_steps.push_back(reg_row(CFG_IDX_SOURCE_WIDTH, 11'd0));
    directed_steps.push_back(req_row(OP_PUSH, 8'h00, 8'h00, 8'h00, 1'b1, ST_ACCEPTED));
    directed_steps.push_back(req_row(OP_PULL, 8'h00, 8'h00, 8'h00, 1'b0, ST_ACCEPTED));
    directed_steps.push_back(req_row(OP_PULL, 8'h00, 8'h00, 8'h00, 1'b0, ST_ACCEPTED));
    // two pixels doubled both ways: no padding, two row copies of four pixels
    directed_steps.push_back(reg_row(CFG_IDX_SCALE_FACTOR, 11'd2));
    directed_steps.push_back(reg_row(CFG_IDX_SOURCE_WIDTH, 11'd2));
    directed_steps.push_back(req_row(OP_PUSH, 8'hff, 8'hff, 8'hff, 1'b1, ST_ACCEPTED));
    directed_steps.push_back(req_row(OP_PUSH, 8'h12, 8'h34, 8'h56, 1'b1, ST_ACCEPTED));
    directed_steps.push_back(req_row(OP_PUSH, 8'h00, 8'h00, 8'h00, 1'b1, ST_BUSY));
    repeat (8)
      directed_steps.push_back(req_row(OP_PULL, 8'h00, 8'h00, 8'h00, 1'b0, ST_ACCEPTED));
    directed_steps.push_back(req_row(OP_PULL, 8'h00, 8'h00, 8'h00, 1'b1, ST_EMPTY));
    // factor field all ones clamps to 100: the 100th pull closes the first row copy
    directed_steps.push_back(reg_row(CFG_IDX_SCALE_FACTOR, 11'h7ff));
    directed_steps.push_back(reg_row(CFG_IDX_SOURCE_WIDTH, 11'd1));
    directed_steps.push_back(req_row(OP_PUSH, 8'ha5, 8'h5a, 8'h3c, 1'b1, ST_ACCEPTED));
    repeat (100)
      directed_steps.push_back(req_row(OP_PULL, 8'h00, 8'h00, 8'h00, 1'b0, ST_ACCEPTED));
    // factor dropped to one mid-burst: the next row copy is the last
    directed_steps.push_back(reg_row(CFG_IDX_SCALE_FACTOR, 11'd1));
    repeat (2)
      directed_steps.push_back(req_row(OP_PULL, 8'h00, 8'h00, 8'h00, 1'b0, ST_ACCEPTED));
    directed_steps.push_back(req_row(OP_PULL, 8'h00, 8'h00, 8'h00, 1'b1, ST_EMPTY));
    // width field all ones clamps to the widest row, so one push leaves it open
    directed_steps.push_back(reg_row(CFG_IDX_SOURCE_WIDTH, 11'h7ff));
    directed_steps.push_back(req_row(OP_PUSH, 8'h11, 8'h22, 8'h33, 1'b1, ST_ACCEPTED));
    directed_steps.push_back(req_row(OP_PULL, 8'h00, 8'h00, 8'h00, 1'b1, ST_EMPTY));
    // width narrowed below the fill count: the next push closes the row
    directed_steps.push_back(reg_row(CFG_IDX_SOURCE_WIDTH, 11'd1));
    directed_steps.push_back(req_row(OP_PUSH, 8'h44, 8'h55, 8'h66, 1'b1, ST_ACCEPTED));
    repeat (2)
      directed_steps.push_back(req_row(OP_PULL, 8'h00, 8'h00, 8'h00, 1'b0, ST_ACCEPTED));
    directed_steps.push_back(req_row(OP_PULL, 8'h00, 8'h00, 8'h00, 1'b1, ST_EMPTY));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == ROW_REG) begin
        wait_drained();
        write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_val);
      end else begin
        send_req(directed_steps[i].req, directed_steps[i].known,
                 directed_steps[i].known_status);
      end
    end

    run_phase(11'd3, 11'd5, 30, 1'b0);
    // receiver holds off while requests keep coming, so the queue backs up
    run_phase(11'd2, 11'd4, 40, 1'b1);
    // rows with no gaps or stalls on either side
    calm = 1'b1;
    run_phase(11'd2, 11'd3, 30, 1'b0);
    calm = 1'b0;
    repeat (3)
      run_phase(reg_val_t'($urandom_range(0, 4)), reg_val_t'($urandom_range(0, 8)), 30, 1'b0);

    wait_drained();
    repeat (10) @(posedge clk);
    if (due_results.size() != 0) flag_mismatch("results still outstanding at end");
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
+incdir+hw/rtl
hw/rtl/pru_pkg.sv
hw/rtl/pru_front.sv
hw/rtl/pru_queue.sv
hw/rtl/pru_back.sv
hw/rtl/pixel_replicate_upscaler.sv
hw/rtl/pru_checker.sv
dv/pixel_replicate_upscaler_tb.sv
